// ----- hdl/snks_pkg.sv -----
// ----------------------------------------------------------------------------
// snks_pkg: shared types and constants of the sorted key node store
// Field widths, command and status codes, word packing and the control
// bundle that the top level hands to every cell of the chain.
// ----------------------------------------------------------------------------
`default_nettype none
package snks_pkg;

  localparam int MAX_KEYS = 16;
  localparam int KEY_W    = 32;
  localparam int CMD_W    = 2;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 5;
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int IDX_W    = $clog2(MAX_KEYS);
  localparam int ICMP_W   = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
  localparam int LCMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd3;

  // commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

  // register indexes
  localparam int REG_ORDER_LIMIT = 0;

  // input word layout
  localparam int IN_CMD_LO   = 0;
  localparam int IN_KEY_LO   = IN_CMD_LO + CMD_W;
  localparam int IN_INDEX_LO = IN_KEY_LO + KEY_W;
  localparam int IN_BITS     = IN_INDEX_LO + INDEX_W;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;

  // output word layout
  localparam int OUT_STATUS_LO  = 0;
  localparam int OUT_PRESENT_LO = OUT_STATUS_LO + STATUS_W;
  localparam int OUT_RKEY_LO    = OUT_PRESENT_LO + 1;
  localparam int OUT_COUNT_LO   = OUT_RKEY_LO + KEY_W;
  localparam int OUT_FULL_LO    = OUT_COUNT_LO + CNT_W;
  localparam int OUT_BITS       = OUT_FULL_LO + 1;
  localparam int OUT_DATA_W     = ((OUT_BITS + 7) / 8) * 8;

  // control bundle broadcast to the cell chain
  typedef struct packed {
    logic               eval;
    logic               ins_en;
    logic               rem_en;
    logic [KEY_W-1:0]   key;
    logic [INDEX_W-1:0] index;
    logic [CNT_W-1:0]   count;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/snks_cell.sv -----
// ----------------------------------------------------------------------------
// snks_cell: one slot of the sorted key chain
// Holds one key, compares it with the command key and shifts with its
// neighbors on insert and remove.
// ----------------------------------------------------------------------------
`default_nettype none
module snks_cell (
  input  wire logic                        clk,
  input  wire logic [snks_pkg::IDX_W-1:0]  cell_idx,
  input  wire snks_pkg::cell_ctl_t         ctl,
  input  wire logic [snks_pkg::KEY_W-1:0]  left_key,
  input  wire logic                        left_right,
  input  wire logic [snks_pkg::KEY_W-1:0]  right_key,
  output logic [snks_pkg::KEY_W-1:0]       key_q,
  output logic                             right_q,
  output logic                             eq_q,
  output logic [snks_pkg::KEY_W-1:0]       rd_q
);

  logic [snks_pkg::KEY_W-1:0] key_r;
  logic                       right_r;
  logic                       eq_r;
  logic [snks_pkg::KEY_W-1:0] rd_r;
  logic                       occ;
  logic                       at_end;
  logic                       idx_hit;

  assign occ     = snks_pkg::CNT_W'(cell_idx) < ctl.count;
  assign at_end  = snks_pkg::CNT_W'(cell_idx) == ctl.count;
  assign idx_hit = snks_pkg::ICMP_W'(cell_idx) == snks_pkg::ICMP_W'(ctl.index);

  // compare flags, taken once per command
  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      right_r <= occ && ($signed(ctl.key) <= $signed(key_r));
      eq_r    <= occ && (ctl.key == key_r);
      rd_r    <= (occ && idx_hit) ? key_r : '0;
    end
  end

  // shift right on insert, left on remove
  always_ff @(posedge clk) begin
    if (ctl.ins_en && (right_r || at_end)) begin
      key_r <= left_right ? left_key : ctl.key;
    end else if (ctl.rem_en && right_r) begin
      key_r <= right_key;
    end
  end

  assign key_q   = key_r;
  assign right_q = right_r;
  assign eq_q    = eq_r;
  assign rd_q    = rd_r;

endmodule
`default_nettype wire

// ----- hdl/sorted_key_node_store.sv -----
// ----------------------------------------------------------------------------
// sorted_key_node_store: ascending store of signed keys, one B-tree node
// Insert, remove, lookup and indexed read on a chain of key cells.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake                 | word
//  --------+-----+---------------------------+-----------------------------
//  in_     | in  | in_tvalid / in_tready     | command, key, index
//  out_    | out | out_tvalid / out_tready   | status, present, read_key,
//          |     |                           | key_count, node_full
//  cfg_    | in  | APB, pready always high   | order_limit at address 0
//
//  Steps: a word is latched on accept; in S_EVAL every cell compares its key;
//  in S_APPLY the cells shift and the result word is registered.
//  Reset: synchronous rst_n clears the count, the full flag and the FSM and
//  loads order_limit with 3; key cells need no clearing.
//  Stalls: a new word is taken while a result waits; the shift step holds
//  until the output register is free.
//
`default_nettype none
module sorted_key_node_store (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // command[1:0], key[33:2], index[37:34], zero pad
  input  wire logic [snks_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // status[1:0], present[2], read_key[34:3], key_count[39:35],
  // node_full[40], zero pad
  output logic [snks_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [2:0]                       cfg_paddr,
  input  wire logic [31:0]                      cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  localparam int N = snks_pkg::MAX_KEYS;

  logic [1:0] state_r, state_nxt;

  logic [snks_pkg::CMD_W-1:0]   cmd_r;
  logic [snks_pkg::KEY_W-1:0]   key_r;
  logic [snks_pkg::INDEX_W-1:0] index_r;

  logic [snks_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic                         full_r, full_nxt;
  logic [snks_pkg::LIMIT_W-1:0] order_limit_r;

  logic [snks_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                            out_valid_r;

  logic [snks_pkg::KEY_W-1:0] cell_key [N];
  logic [snks_pkg::KEY_W-1:0] cell_rd  [N];
  logic [N-1:0]               cell_right;
  logic [N-1:0]               cell_eq;

  snks_pkg::cell_ctl_t ctl;

  logic in_fire, apply_fire, found, cfg_wr;
  logic [snks_pkg::KEY_W-1:0] rd_any;
  logic [snks_pkg::CNT_W-1:0] count_inc;
  logic [snks_pkg::STATUS_W-1:0] status;
  logic present;

  // ---- configuration port ----
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == 1'(snks_pkg::REG_ORDER_LIMIT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_limit_r <= snks_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      order_limit_r <= cfg_pwdata[snks_pkg::LIMIT_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == 1'(snks_pkg::REG_ORDER_LIMIT))
                      ? 32'(order_limit_r) : '0;

  // ---- sequencing ----
  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  // shift only once the output register can take the result
  assign apply_fire = (state_r == S_APPLY) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_EVAL;
      S_EVAL:  state_nxt = S_APPLY;
      S_APPLY: if (apply_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // latch the command word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_tdata[snks_pkg::IN_CMD_LO +: snks_pkg::CMD_W];
      key_r   <= in_tdata[snks_pkg::IN_KEY_LO +: snks_pkg::KEY_W];
      index_r <= in_tdata[snks_pkg::IN_INDEX_LO +: snks_pkg::INDEX_W];
    end
  end

  // ---- combine cell answers ----
  // eq flags are already masked by occupancy, so any hit means stored
  assign found = |cell_eq;

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < N; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
  end

  assign count_inc = count_r + 1'b1;

  always_comb begin
    ctl.eval   = (state_r == S_EVAL);
    ctl.ins_en = apply_fire && (cmd_r == snks_pkg::CMD_INSERT)
                 && (count_r < snks_pkg::CNT_W'(N));
    ctl.rem_en = apply_fire && (cmd_r == snks_pkg::CMD_REMOVE) && found;
    ctl.key    = key_r;
    ctl.index  = index_r;
    ctl.count  = count_r;
  end

  always_comb begin
    count_nxt = count_r;
    full_nxt  = full_r;
    status    = snks_pkg::ST_OK;
    present   = 1'b0;
    case (cmd_r)
      snks_pkg::CMD_INSERT: begin
        if (count_r < snks_pkg::CNT_W'(N)) begin
          count_nxt = count_inc;
          // mark full once the new count reaches the limit
          if (snks_pkg::LCMP_W'(count_inc) >= snks_pkg::LCMP_W'(order_limit_r)) begin
            full_nxt = 1'b1;
          end
        end else begin
          status = snks_pkg::ST_OVERFLOW;
        end
      end
      snks_pkg::CMD_REMOVE: begin
        if (found) begin
          count_nxt = count_r - 1'b1;
          full_nxt  = 1'b0;
        end else begin
          status = snks_pkg::ST_NOT_FOUND;
        end
      end
      snks_pkg::CMD_LOOKUP: present = found;
      default: ;
    endcase
  end

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[snks_pkg::OUT_STATUS_LO +: snks_pkg::STATUS_W] = status;
    out_data_nxt[snks_pkg::OUT_PRESENT_LO]                      = present;
    out_data_nxt[snks_pkg::OUT_RKEY_LO +: snks_pkg::KEY_W] =
      (cmd_r == snks_pkg::CMD_READ) ? rd_any : '0;
    out_data_nxt[snks_pkg::OUT_COUNT_LO +: snks_pkg::CNT_W]     = count_nxt;
    out_data_nxt[snks_pkg::OUT_FULL_LO]                         = full_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (apply_fire) begin
        count_r     <= count_nxt;
        full_r      <= full_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---- cell chain ----
  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [snks_pkg::KEY_W-1:0] lkey;
    logic                       lright;
    logic [snks_pkg::KEY_W-1:0] rkey;

    if (g == 0) begin : g_first
      assign lkey   = '0;
      assign lright = 1'b0;
    end else begin : g_mid
      assign lkey   = cell_key[g-1];
      assign lright = cell_right[g-1];
    end

    if (g == N - 1) begin : g_last
      // hold: this slot leaves the occupied range on remove
      assign rkey = cell_key[g];
    end else begin : g_inner
      assign rkey = cell_key[g+1];
    end

    snks_cell u_cell (
      .clk        (clk),
      .cell_idx   (snks_pkg::IDX_W'(g)),
      .ctl        (ctl),
      .left_key   (lkey),
      .left_right (lright),
      .right_key  (rkey),
      .key_q      (cell_key[g]),
      .right_q    (cell_right[g]),
      .eq_q       (cell_eq[g]),
      .rd_q       (cell_rd[g])
    );
  end

endmodule
`default_nettype wire

// ----- hdl/snks_checker.sv -----
// ----------------------------------------------------------------------------
// snks_checker: port-level checks of the sorted key node store
// Watches the stream and result words on the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module snks_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic [snks_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // one word in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while one is in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      out_tdata[snks_pkg::OUT_STATUS_LO +: snks_pkg::STATUS_W] == snks_pkg::ST_OK ||
      out_tdata[snks_pkg::OUT_STATUS_LO +: snks_pkg::STATUS_W] == snks_pkg::ST_NOT_FOUND ||
      out_tdata[snks_pkg::OUT_STATUS_LO +: snks_pkg::STATUS_W] == snks_pkg::ST_OVERFLOW)
    else $error("bad status code");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      out_tdata[snks_pkg::OUT_COUNT_LO +: snks_pkg::CNT_W] <=
      snks_pkg::CNT_W'(snks_pkg::MAX_KEYS))
    else $error("key count past capacity");

  // a found key never comes with an error status
  a_present_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[snks_pkg::OUT_PRESENT_LO] |->
      out_tdata[snks_pkg::OUT_STATUS_LO +: snks_pkg::STATUS_W] == snks_pkg::ST_OK)
    else $error("present flag with error status");

endmodule

bind sorted_key_node_store snks_checker u_snks_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
`default_nettype wire
